### rtl/mik_pkg.sv
// Shared types, constants and the CORDIC angle table for the mecanum kinematics block.
package mik_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int CORDIC_MAX = 24;
	localparam int N_CELLS = (CORDIC_STAGES > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STAGES;
	localparam int STAGE_IDX_W = $clog2(CORDIC_MAX);

	// Cells, then gain/lever arm, wheel mix, radius multiply, round and saturate.
	localparam int LATENCY = N_CELLS + 4;

	localparam int VEL_W = 32;
	localparam int ANG_W = 33;
	localparam int MIX_W = 36;
	localparam int SPEED_W = 24;

	localparam logic signed [17:0] INV_GAIN_Q16 = 18'sd39797;
	localparam logic signed [ANG_W-1:0] HALF_TURN = 33'sh0_8000_0000;
	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'sh7F_FFFF;
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'sh80_0000;

	typedef enum logic [1:0] {
		CFG_HALF_LEN_X = 2'd0,
		CFG_HALF_LEN_Y = 2'd1,
		CFG_INV_RADIUS = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic op;
		logic signed [VEL_W-1:0] x;
		logic signed [VEL_W-1:0] y;
		logic signed [ANG_W-1:0] z;
		logic signed [15:0] wz;
	} vec_t;

	// Arctangent of 2^-i in units of pi/2^31.
	function automatic logic signed [ANG_W-1:0] atan_angle(input logic [STAGE_IDX_W-1:0] idx);
		logic signed [ANG_W-1:0] a;
		case (idx)
			5'd0: a = 33'sd536870912;
			5'd1: a = 33'sd316933405;
			5'd2: a = 33'sd167458907;
			5'd3: a = 33'sd85004756;
			5'd4: a = 33'sd42667331;
			5'd5: a = 33'sd21354465;
			5'd6: a = 33'sd10679838;
			5'd7: a = 33'sd5340245;
			5'd8: a = 33'sd2670163;
			5'd9: a = 33'sd1335087;
			5'd10: a = 33'sd667544;
			5'd11: a = 33'sd333772;
			5'd12: a = 33'sd166886;
			5'd13: a = 33'sd83443;
			5'd14: a = 33'sd41721;
			5'd15: a = 33'sd20860;
			5'd16: a = 33'sd10430;
			5'd17: a = 33'sd5215;
			5'd18: a = 33'sd2607;
			5'd19: a = 33'sd1303;
			5'd20: a = 33'sd651;
			5'd21: a = 33'sd325;
			5'd22: a = 33'sd162;
			5'd23: a = 33'sd81;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

### rtl/mik_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with its pipeline register.
module mik_cordic_cell import mik_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [STAGE_IDX_W-1:0] stage,
	input  logic vld_in,
	input  vec_t vec_in,
	output logic vld_out,
	output vec_t vec_out
);

	logic signed [VEL_W-1:0] x_in;
	logic signed [VEL_W-1:0] y_in;
	logic signed [ANG_W-1:0] z_in;
	logic signed [VEL_W-1:0] dx;
	logic signed [VEL_W-1:0] dy;
	logic signed [ANG_W-1:0] da;
	vec_t nxt;
	logic vld_s1;
	vec_t vec_s1;

	assign x_in = vec_in.x;
	assign y_in = vec_in.y;
	assign z_in = vec_in.z;
	assign dx = y_in >>> stage;
	assign dy = x_in >>> stage;
	assign da = atan_angle(stage);

	always_comb begin
		nxt = vec_in;
		// In body-frame mode the vector passes through untouched.
		if (vec_in.op) begin
			if (z_in >= 0) begin
				nxt.x = x_in - dx;
				nxt.y = y_in + dy;
				nxt.z = z_in - da;
			end else begin
				nxt.x = x_in + dx;
				nxt.y = y_in - dy;
				nxt.z = z_in + da;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= nxt;
	end

	assign vld_out = vld_s1;
	assign vec_out = vec_s1;

endmodule

### rtl/mik_wheel.sv
// One wheel: scale by reciprocal radius, round to Q12.12 and saturate.
module mik_wheel import mik_pkg::*; (
	input  logic clk,
	input  logic signed [MIX_W-1:0] mix,
	input  logic [15:0] inv_radius,
	output logic signed [SPEED_W-1:0] speed,
	output logic sat
);

	localparam int PROD_W = MIX_W + 17;
	localparam int SHR_W = PROD_W - 22;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] rnd;
	logic signed [SHR_W-1:0] shr;
	logic signed [SPEED_W-1:0] speed_s2;
	logic sat_s2;
	logic signed [SPEED_W-1:0] speed_n;
	logic sat_n;

	always_ff @(posedge clk) begin
		prod_s1 <= mix * $signed({1'b0, inv_radius});
	end

	assign rnd = prod_s1 + PROD_W'(64'sd2097152);
	assign shr = SHR_W'(rnd >>> 22);

	always_comb begin
		if (shr > SHR_W'(SPEED_MAX)) begin
			speed_n = SPEED_MAX;
			sat_n = 1'b1;
		end else if (shr < SHR_W'(SPEED_MIN)) begin
			speed_n = SPEED_MIN;
			sat_n = 1'b1;
		end else begin
			speed_n = SPEED_W'(shr);
			sat_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		speed_s2 <= speed_n;
		sat_s2 <= sat_n;
	end

	assign speed = speed_s2;
	assign sat = sat_s2;

endmodule

### rtl/mecanum_inverse_kinematics.sv
// Top level: heading rotation through a CORDIC cell chain, then the four wheel speeds.
//
// A command is taken on every clock edge where start is high; busy stays low, so one
// command per cycle is sustained. Each command yields one result, shown for one cycle
// with done high, once it has passed through the CORDIC cells, one register per cell,
// then through registers for the gain and lever-arm products, wheel mixing, the radius
// multiply, and rounding with saturation. The receiver cannot stall, so results must be
// captured when done is high. Configuration writes take effect on the next edge and
// should only be made while no command is in flight.
module mecanum_inverse_kinematics import mik_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic op,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic signed [15:0] yaw_rate,
	input  logic signed [15:0] heading,
	output logic done,
	output logic signed [SPEED_W-1:0] speed_left_front,
	output logic signed [SPEED_W-1:0] speed_right_front,
	output logic signed [SPEED_W-1:0] speed_left_back,
	output logic signed [SPEED_W-1:0] speed_right_back,
	output logic saturated,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] half_x_q;
	logic [15:0] half_y_q;
	logic [15:0] inv_radius_q;

	vec_t chain [0:N_CELLS];
	logic vld_chain [0:N_CELLS];

	logic signed [VEL_W-1:0] ux0;
	logic signed [VEL_W-1:0] uy0;
	logic signed [ANG_W-1:0] z0;
	logic wrap_pos;
	logic wrap_neg;

	logic signed [VEL_W+17:0] gx;
	logic signed [VEL_W+17:0] gy;
	logic [16:0] lever;
	logic signed [VEL_W-1:0] ux_s1;
	logic signed [VEL_W-1:0] uy_s1;
	logic signed [33:0] lw_s1;
	logic vld_s1;

	logic signed [MIX_W-1:0] ux_e;
	logic signed [MIX_W-1:0] uy_e;
	logic signed [MIX_W-1:0] lw_e;
	logic signed [MIX_W-1:0] mix_s2 [0:3];
	logic vld_s2;
	logic vld_s3;
	logic done_q;

	logic signed [SPEED_W-1:0] spd [0:3];
	logic sat_w [0:3];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_x_q <= 16'd4096;
			half_y_q <= 16'd4096;
			inv_radius_q <= 16'd5120;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HALF_LEN_X: half_x_q <= cfg_wdata;
				CFG_HALF_LEN_Y: half_y_q <= cfg_wdata;
				CFG_INV_RADIUS: inv_radius_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Headings past a quarter turn are folded back by negating the vector.
	assign wrap_pos = heading > 16'sd16384;
	assign wrap_neg = heading < -16'sd16384;
	assign ux0 = $signed({{2{vel_x[15]}}, vel_x, 14'b0});
	assign uy0 = $signed({{2{vel_y[15]}}, vel_y, 14'b0});

	always_comb begin
		z0 = $signed({heading[15], heading, 16'b0});
		chain[0].op = op;
		chain[0].wz = yaw_rate;
		chain[0].x = ux0;
		chain[0].y = uy0;
		if (op && (wrap_pos || wrap_neg)) begin
			chain[0].x = -ux0;
			chain[0].y = -uy0;
		end
		if (wrap_pos) begin
			z0 = z0 - HALF_TURN;
		end else if (wrap_neg) begin
			z0 = z0 + HALF_TURN;
		end
		chain[0].z = z0;
	end

	assign vld_chain[0] = start && !busy;

	for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
		mik_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.stage   (STAGE_IDX_W'(g)),
			.vld_in  (vld_chain[g]),
			.vec_in  (chain[g]),
			.vld_out (vld_chain[g+1]),
			.vec_out (chain[g+1])
		);
	end

	// Gain compensation and the lever-arm product for the yaw term.
	assign gx = chain[N_CELLS].x * INV_GAIN_Q16;
	assign gy = chain[N_CELLS].y * INV_GAIN_Q16;
	assign lever = {1'b0, half_x_q} + {1'b0, half_y_q};

	always_ff @(posedge clk) begin
		ux_s1 <= chain[N_CELLS].op ? gx[VEL_W+15:16] : chain[N_CELLS].x;
		uy_s1 <= chain[N_CELLS].op ? gy[VEL_W+15:16] : chain[N_CELLS].y;
		lw_s1 <= $signed({1'b0, lever}) * chain[N_CELLS].wz;
	end

	assign ux_e = MIX_W'(ux_s1);
	assign uy_e = MIX_W'(uy_s1);
	assign lw_e = MIX_W'(lw_s1);

	always_ff @(posedge clk) begin
		mix_s2[0] <= ux_e - uy_e - lw_e;
		mix_s2[1] <= -(ux_e + uy_e + lw_e);
		mix_s2[2] <= ux_e + uy_e - lw_e;
		mix_s2[3] <= -(ux_e - uy_e + lw_e);
	end

	for (genvar w = 0; w < 4; w++) begin : g_wheel
		mik_wheel u_wheel (
			.clk        (clk),
			.mix        (mix_s2[w]),
			.inv_radius (inv_radius_q),
			.speed      (spd[w]),
			.sat        (sat_w[w])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= vld_chain[N_CELLS];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	assign done = done_q;
	assign speed_left_front = spd[0];
	assign speed_right_front = spd[1];
	assign speed_left_back = spd[2];
	assign speed_right_back = spd[3];
	assign saturated = sat_w[0] || sat_w[1] || sat_w[2] || sat_w[3];

	// Every accepted transaction comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("accepted transaction did not complete on time");

	// A result never appears without a transaction accepted earlier.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching transaction");

	// A saturation flag must come with a speed pinned at a limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
			(speed_left_front == SPEED_MAX || speed_left_front == SPEED_MIN ||
			 speed_right_front == SPEED_MAX || speed_right_front == SPEED_MIN ||
			 speed_left_back == SPEED_MAX || speed_left_back == SPEED_MIN ||
			 speed_right_back == SPEED_MAX || speed_right_back == SPEED_MIN))
		else $error("saturation flagged with no speed at a limit");

endmodule

### tb/sv/mecanum_inverse_kinematics_test.sv
// Self-checking testbench for the mecanum inverse kinematics block with heading rotation.
module mecanum_inverse_kinematics_test;
	import mik_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROT_STAGES = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
	localparam int PHASE_ITEMS = 250;
	localparam int NUM_PHASES = 8;
	localparam int NUM_ROWS = 28;

	typedef struct packed {
		logic signed [SPEED_W-1:0] lf;
		logic signed [SPEED_W-1:0] rf;
		logic signed [SPEED_W-1:0] lb;
		logic signed [SPEED_W-1:0] rb;
		logic sat;
	} wheel_speeds_t;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_TYPED,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		cfg_idx_t reg_idx;
		logic [15:0] reg_val;
		logic op;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] wz;
		logic signed [15:0] hd;
		wheel_speeds_t speeds;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic op = 1'b0;
	logic signed [15:0] vel_x = '0;
	logic signed [15:0] vel_y = '0;
	logic signed [15:0] yaw_rate = '0;
	logic signed [15:0] heading = '0;
	logic done;
	logic signed [SPEED_W-1:0] speed_left_front;
	logic signed [SPEED_W-1:0] speed_right_front;
	logic signed [SPEED_W-1:0] speed_left_back;
	logic signed [SPEED_W-1:0] speed_right_back;
	logic saturated;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	// Geometry as the block holds it after reset.
	logic [15:0] geo_half_x = 16'd4096;
	logic [15:0] geo_half_y = 16'd4096;
	logic [15:0] geo_inv_radius = 16'd5120;

	wheel_speeds_t pending_speeds[$];
	int fail_count = 0;

	// Expected speeds are typed in only where they follow at a glance.
	stim_row_t dir_rows [0:NUM_ROWS-1] = '{
		'{ROW_TYPED, CFG_HALF_LEN_X, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
			'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}},
		'{ROW_TYPED, CFG_HALF_LEN_X, 16'd0, 1'b0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0,
			'{24'sd655340, -24'sd655340, 24'sd655340, -24'sd655340, 1'b0}},
		'{ROW_TYPED, CFG_HALF_LEN_X, 16'd0, 1'b0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0,
			'{-24'sd655360, 24'sd655360, -24'sd655360, 24'sd655360, 1'b0}},
		'{ROW_TYPED, CFG_HALF_LEN_X, 16'd0, 1'b0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0,
			'{-24'sd81920, -24'sd81920, 24'sd81920, 24'sd81920, 1'b0}},
		'{ROW_TYPED, CFG_HALF_LEN_X, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0,
			'{-24'sd40960, -24'sd40960, -24'sd40960, -24'sd40960, 1'b0}},
		// The heading must have no effect in body frame.
		'{ROW_TYPED, CFG_HALF_LEN_X, 16'd0, 1'b0, 16'sd4096, 16'sd0, 16'sd0, 16'sd12345,
			'{24'sd81920, -24'sd81920, 24'sd81920, -24'sd81920, 1'b0}},
		'{ROW_TYPED, CFG_HALF_LEN_X, 16'd0, 1'b1, 16'sd0, 16'sd0, 16'sd0, -16'sd32768,
			'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}},
		'{ROW_PREDICT, CFG_HALF_LEN_X, 16'd0, 1'b1, 16'sd4096, 16'sd0, 16'sd0, 16'sd0,
			'0},
		'{ROW_PREDICT, CFG_HALF_LEN_X, 16'd0, 1'b1, 16'sd4096, -16'sd2048, 16'sd0,
			16'sd16384, '0},
		'{ROW_PREDICT, CFG_HALF_LEN_X, 16'd0, 1'b1, 16'sd4096, 16'sd2048, 16'sd0,
			16'sd16385, '0},
		'{ROW_PREDICT, CFG_HALF_LEN_X, 16'd0, 1'b1, -16'sd4096, 16'sd2048, 16'sd0,
			-16'sd16384, '0},
		'{ROW_PREDICT, CFG_HALF_LEN_X, 16'd0, 1'b1, -16'sd4096, -16'sd2048, 16'sd0,
			-16'sd16385, '0},
		'{ROW_PREDICT, CFG_HALF_LEN_X, 16'd0, 1'b1, 16'sd32767, 16'sd32767, -16'sd32768,
			16'sd32767, '0},
		'{ROW_PREDICT, CFG_HALF_LEN_X, 16'd0, 1'b1, -16'sd32768, -16'sd32768, 16'sd32767,
			-16'sd32768, '0},
		'{ROW_PREDICT, CFG_HALF_LEN_X, 16'd0, 1'b1, 16'sd1000, 16'sd3000, -16'sd500,
			16'sd8192, '0},
		'{ROW_CFG, CFG_HALF_LEN_X, 16'd65535, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, '0},
		'{ROW_CFG, CFG_HALF_LEN_Y, 16'd65535, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, '0},
		'{ROW_CFG, CFG_INV_RADIUS, 16'd65535, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, '0},
		'{ROW_TYPED, CFG_HALF_LEN_X, 16'd0, 1'b0, 16'sd32767, -16'sd32768, 16'sd32767,
			16'sd0, '{SPEED_MIN, SPEED_MIN, SPEED_MIN, SPEED_MIN, 1'b1}},
		'{ROW_TYPED, CFG_HALF_LEN_X, 16'd0, 1'b0, 16'sd32767, -16'sd32768, -16'sd32768,
			16'sd0, '{SPEED_MAX, SPEED_MAX, SPEED_MAX, SPEED_MAX, 1'b1}},
		'{ROW_PREDICT, CFG_HALF_LEN_X, 16'd0, 1'b1, 16'sd100, 16'sd0, 16'sd0,
			-16'sd16385, '0},
		// A zero reciprocal radius forces every speed to zero.
		'{ROW_CFG, CFG_INV_RADIUS, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, '0},
		'{ROW_TYPED, CFG_HALF_LEN_X, 16'd0, 1'b1, 16'sd32767, -16'sd32768, 16'sd32767,
			-16'sd32768, '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}},
		'{ROW_CFG, CFG_HALF_LEN_X, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, '0},
		'{ROW_CFG, CFG_HALF_LEN_Y, 16'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, '0},
		'{ROW_CFG, CFG_INV_RADIUS, 16'd1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, '0},
		'{ROW_PREDICT, CFG_HALF_LEN_X, 16'd0, 1'b0, -16'sd1, 16'sd1, 16'sd32767, 16'sd0,
			'0},
		'{ROW_PREDICT, CFG_HALF_LEN_X, 16'd0, 1'b1, 16'sd32767, 16'sd0, 16'sd0,
			-16'sd16385, '0}
	};

	mecanum_inverse_kinematics uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.yaw_rate(yaw_rate),
		.heading(heading),
		.done(done),
		.speed_left_front(speed_left_front),
		.speed_right_front(speed_right_front),
		.speed_left_back(speed_left_back),
		.speed_right_back(speed_right_back),
		.saturated(saturated),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint cordic_atan(input int i);
		longint a;
		case (i)
			0: a = 536870912;
			1: a = 316933405;
			2: a = 167458907;
			3: a = 85004756;
			4: a = 42667331;
			5: a = 21354465;
			6: a = 10679838;
			7: a = 5340245;
			8: a = 2670163;
			9: a = 1335087;
			10: a = 667544;
			11: a = 333772;
			12: a = 166886;
			13: a = 83443;
			14: a = 41721;
			15: a = 20860;
			16: a = 10430;
			17: a = 5215;
			18: a = 2607;
			19: a = 1303;
			20: a = 651;
			21: a = 325;
			22: a = 162;
			23: a = 81;
			default: a = 0;
		endcase
		return a;
	endfunction

	// Q.26 mix times the Q8.8 reciprocal radius, rounded half up to Q.12.
	function automatic longint scale_by_radius(input longint mix);
		longint prod;
		prod = mix * longint'(geo_inv_radius);
		return (prod + (longint'(1) << 21)) >>> 22;
	endfunction

	function automatic wheel_speeds_t predict_speeds(input logic rot,
			input logic signed [15:0] vx, input logic signed [15:0] vy,
			input logic signed [15:0] wz, input logic signed [15:0] hd);
		wheel_speeds_t res;
		longint ux, uy, x, y, z, dx, dy, lever, raw[4];
		logic signed [SPEED_W-1:0] clip[4];
		logic sat;
		ux = longint'(vx) * 16384;
		uy = longint'(vy) * 16384;
		sat = 1'b0;
		if (rot) begin
			x = ux;
			y = uy;
			z = longint'(hd) * 65536;
			// Past a quarter turn, pre-rotate by half a turn so the CORDIC converges.
			if (hd > 16384) begin
				x = -x;
				y = -y;
				z = z - (longint'(1) << 31);
			end else if (hd < -16384) begin
				x = -x;
				y = -y;
				z = z + (longint'(1) << 31);
			end
			for (int i = 0; i < ROT_STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - cordic_atan(i);
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + cordic_atan(i);
				end
			end
			ux = (x * 39797) >>> 16;
			uy = (y * 39797) >>> 16;
		end
		lever = (longint'(geo_half_x) + longint'(geo_half_y)) * longint'(wz);
		raw[0] = scale_by_radius(ux - uy - lever);
		raw[1] = scale_by_radius(-(ux + uy + lever));
		raw[2] = scale_by_radius(ux + uy - lever);
		raw[3] = scale_by_radius(-(ux - uy + lever));
		for (int k = 0; k < 4; k++) begin
			if (raw[k] > 64'sd8388607) begin
				clip[k] = SPEED_MAX;
				sat = 1'b1;
			end else if (raw[k] < -64'sd8388608) begin
				clip[k] = SPEED_MIN;
				sat = 1'b1;
			end else begin
				clip[k] = raw[k][SPEED_W-1:0];
			end
		end
		res.lf = clip[0];
		res.rf = clip[1];
		res.lb = clip[2];
		res.rb = clip[3];
		res.sat = sat;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic signed [SPEED_W-1:0] got,
			input logic signed [SPEED_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// Results cannot be held off, so every done cycle is one transaction.
	always @(posedge clk) begin
		wheel_speeds_t want;
		if (arst_n === 1'b1) begin
			if (done === 1'b1) begin
				if (pending_speeds.size() == 0) begin
					report_mismatch("result with no command outstanding");
				end else begin
					want = pending_speeds.pop_front();
					check_field("speed_left_front", speed_left_front, want.lf);
					check_field("speed_right_front", speed_right_front, want.rf);
					check_field("speed_left_back", speed_left_back, want.lb);
					check_field("speed_right_back", speed_right_back, want.rb);
					check_field("saturated", saturated, want.sat);
				end
			end else if (done !== 1'b0) begin
				report_mismatch("done is unknown");
			end
		end
	end

	task automatic wait_drained();
		while (pending_speeds.size() != 0)
			@(posedge clk);
	endtask

	// Leaves cfg_we high so that writes can follow back to back.
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_HALF_LEN_X: geo_half_x = val;
			CFG_HALF_LEN_Y: geo_half_y = val;
			CFG_INV_RADIUS: geo_inv_radius = val;
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [15:0] hx, input logic [15:0] hy,
			input logic [15:0] ir);
		write_reg(CFG_HALF_LEN_X, hx);
		write_reg(CFG_HALF_LEN_Y, hy);
		write_reg(CFG_INV_RADIUS, ir);
		cfg_we <= 1'b0;
	endtask

	task automatic issue(input logic rot, input logic signed [15:0] vx,
			input logic signed [15:0] vy, input logic signed [15:0] wz,
			input logic signed [15:0] hd, input bit typed, input wheel_speeds_t typed_speeds);
		start <= 1'b1;
		op <= rot;
		vel_x <= vx;
		vel_y <= vy;
		yaw_rate <= wz;
		heading <= hd;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (typed)
			pending_speeds.push_back(typed_speeds);
		else
			pending_speeds.push_back(predict_speeds(rot, vx, vy, wz, hd));
	endtask

	function automatic logic signed [15:0] rand_velocity();
		logic signed [15:0] v;
		case ($urandom_range(0, 7))
			0: v = 16'sd32767;
			1: v = -16'sd32768;
			2: v = 16'($urandom_range(0, 512)) - 16'sd256;
			3: v = 16'sd0;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] rand_heading();
		logic signed [15:0] h;
		case ($urandom_range(0, 11))
			0: h = 16'sd16384;
			1: h = 16'sd16385;
			2: h = -16'sd16384;
			3: h = -16'sd16385;
			4: h = 16'sd32767;
			5: h = -16'sd32768;
			6: h = 16'sd0;
			default: h = 16'($urandom);
		endcase
		return h;
	endfunction

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		stim_row_t row;
		logic [15:0] hx, hy, ir;
		int sent, burst, gap;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG) begin
				start <= 1'b0;
				wait_drained();
				write_reg(row.reg_idx, row.reg_val);
				if (i == NUM_ROWS - 1 || dir_rows[i + 1].kind != ROW_CFG)
					cfg_we <= 1'b0;
			end else begin
				issue(row.op, row.vx, row.vy, row.wz, row.hd, row.kind == ROW_TYPED,
					row.speeds);
			end
		end
		start <= 1'b0;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					hx = 16'd4096;
					hy = 16'd4096;
					ir = 16'd5120;
				end
				1: begin
					hx = 16'hFFFF;
					hy = 16'hFFFF;
					ir = 16'hFFFF;
				end
				2: begin
					hx = 16'd0;
					hy = 16'd0;
					ir = 16'd1;
				end
				default: begin
					hx = 16'($urandom);
					hy = 16'($urandom);
					// Mostly modest radii so that many results stay in range.
					if ($urandom_range(0, 2) == 0)
						ir = 16'($urandom_range(1, 65535));
					else
						ir = 16'($urandom_range(1, 2048));
				end
			endcase
			set_geometry(hx, hy, ir);

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
					: $urandom_range(1, 16);
				for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
					issue(1'($urandom), rand_velocity(), rand_velocity(), rand_velocity(),
						rand_heading(), 1'b0, '0);
					sent++;
				end
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				if ($urandom_range(0, 30) == 0) begin
					// Let the pipeline empty completely before going on.
					start <= 1'b0;
					wait_drained();
				end else if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			start <= 1'b0;
		end

		wait_drained();
		repeat (LATENCY + 4) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### sim.f
rtl/mik_pkg.sv
rtl/mik_cordic_cell.sv
rtl/mik_wheel.sv
rtl/mecanum_inverse_kinematics.sv
tb/sv/mecanum_inverse_kinematics_test.sv
